[src/msrl_pkg.sv]
`default_nettype none
package msrl_pkg;

   localparam int CHANNELS  = 8;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // magnitude of (difference + half period) needs 33 bits
   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [7:0] CSR_MAX_STEP    = 8'd0;
   localparam logic [7:0] CSR_WRAP_PERIOD = 8'd1;

   localparam logic [30:0] MAX_STEP_RESET    = 31'd65536;
   localparam logic [30:0] WRAP_PERIOD_RESET = 31'd0;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_PRESET = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_BIAS,
      ST_ABS,
      ST_DIV,
      ST_FIX,
      ST_UNBIAS,
      ST_CLAMP,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage
`default_nettype wire

[src/msrl_rem_unit.sv]
`default_nettype none
module msrl_rem_unit
   import msrl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_STEPS-1:0] dividend,
   input  wire logic [30:0]          divisor,
   output logic      [30:0]          rem,
   output rem_status_type            status
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_STEPS-1:0] num_ff, num_in;
   logic [30:0]          rem_ff, rem_in;

   logic [31:0] shifted;
   logic [31:0] trial;
   logic        fits;

   // one restoring step per cycle: shift in the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, num_ff[DIV_STEPS-1]};
   assign trial   = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[30:0] : shifted[30:0];
         num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign rem         = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

[src/multichannel_slew_rate_limiter_top.sv]
`default_nettype none
// Per-channel slew-rate limiter for signed Q16.16 data. A sample item moves its
// channel's level toward the target by at most max_step, taking the short way
// round a period when wrap_period is nonzero; a preset item loads the level.
// Every item yields one result: the new level, or zero for a channel out of
// range, which leaves the levels unchanged. Items are handled one at a time and
// req_stall is high while one is in work; a wrapped sample also waits on the
// 33-step bit-serial remainder unit that reduces the difference by the period,
// and any item waits while the output register stays full. Results sit in an
// output register, so a new item is taken while one waits.
// Register writes (index 0 max_step, 1 wrap_period) are taken every cycle and
// must be made only while the block is idle.
module multichannel_slew_rate_limiter_top
   import msrl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [2:0]         req_channel,
   input  wire logic signed [31:0] req_sample_value,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_out_channel,
   output logic signed [31:0]      rsp_filtered_value,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   state_type state_ff, state_in;

   logic [30:0] max_step_ff;
   logic [30:0] wrap_ff;

   logic signed [31:0] level_ff [CHANNELS];

   logic [2:0]         ch_ff, ch_in;
   logic               in_range_ff, in_range_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] cur_ff, cur_in;
   logic signed [33:0] work_ff, work_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] res_ff, res_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_ch_ff;
   logic signed [31:0] rsp_val_ff;
   logic               rsp_load;
   logic               level_we;

   logic                 rem_start;
   logic [DIV_STEPS-1:0] rem_dividend;
   logic [30:0]          rem_val;
   rem_status_type       rem_status;

   logic [CH_IDX_W-1:0] idx;
   logic [29:0]         half;
   logic signed [33:0]  lim_pos;
   logic signed [33:0]  lim_neg;
   logic signed [33:0]  sum;
   logic                req_in_range;

   assign idx          = CH_IDX_W'(ch_ff);
   assign half         = wrap_ff[30:1];
   assign lim_pos      = $signed({3'b000, max_step_ff});
   assign lim_neg      = -lim_pos;
   assign sum          = $signed({{2{cur_ff[31]}}, cur_ff}) + work_ff;
   assign req_in_range = {29'd0, req_channel} < 32'(CHANNELS);

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   msrl_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (wrap_ff),
      .rem      (rem_val),
      .status   (rem_status)
   );

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      in_range_in  = in_range_ff;
      target_in    = target_ff;
      cur_in       = cur_ff;
      work_in      = work_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rem_start    = 1'b0;
      rem_dividend = work_ff[DIV_STEPS-1:0];
      rsp_load     = 1'b0;
      level_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in       = req_channel;
               in_range_in = req_in_range;
               target_in   = req_sample_value;
               if (!req_in_range) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else if (req_kind == KIND_PRESET) begin
                  res_in   = req_sample_value;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            cur_in   = level_ff[idx];
            work_in  = $signed({{2{target_ff[31]}}, target_ff})
                     - $signed({{2{level_ff[idx][31]}}, level_ff[idx]});
            state_in = (wrap_ff != '0) ? ST_BIAS : ST_CLAMP;
         end
         ST_BIAS: begin
            work_in  = work_ff + $signed({4'b0000, half});
            state_in = ST_ABS;
         end
         ST_ABS: begin
            // divide the magnitude, fix the sign of the remainder afterward
            neg_in       = work_ff[33];
            rem_start    = 1'b1;
            rem_dividend = work_ff[33] ? DIV_STEPS'(-work_ff) : work_ff[DIV_STEPS-1:0];
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (rem_status.done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (neg_ff && rem_val != '0) begin
               work_in = $signed({3'b000, wrap_ff - rem_val});
            end else begin
               work_in = $signed({3'b000, rem_val});
            end
            state_in = ST_UNBIAS;
         end
         ST_UNBIAS: begin
            work_in  = work_ff - $signed({4'b0000, half});
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (work_ff > lim_pos) begin
               work_in = lim_pos;
            end else if (work_ff < lim_neg) begin
               work_in = lim_neg;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (sum > 34'sd2147483647) begin
               res_in = 32'sh7FFF_FFFF;
            end else if (sum < -34'sd2147483648) begin
               res_in = 32'sh8000_0000;
            end else begin
               res_in = sum[31:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               level_we = in_range_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      in_range_ff <= in_range_in;
      target_ff   <= target_in;
      cur_ff      <= cur_in;
      work_ff     <= work_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      if (rsp_load) begin
         rsp_ch_ff  <= ch_ff;
         rsp_val_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= MAX_STEP_RESET;
         wrap_ff     <= WRAP_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MAX_STEP) begin
            max_step_ff <= csr_data[30:0];
         end else if (csr_index == CSR_WRAP_PERIOD) begin
            wrap_ff <= csr_data[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i] <= '0;
         end
      end else if (level_we) begin
         level_ff[idx] <= res_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_ch_ff;
   assign rsp_filtered_value = rsp_val_ff;

   a_rem_busy_in_div : assert property (@(posedge clock) disable iff (reset)
      rem_status.busy |-> state_ff == ST_DIV)
      else $error("remainder unit busy outside divide step");

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE)
      else $error("accepted item did not start");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");

   a_done_leaves_div : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && rem_status.done) |=> state_ff == ST_FIX)
      else $error("remainder done not taken");

endmodule
`default_nettype wire
